>>> rtl/assembly_token_scanner_unit_defines.svh
// ---------------------------------------------------------------------------
// Assembly token scanner - assertion macros
// Shared property wrappers for the scanner's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef ASSEMBLY_TOKEN_SCANNER_UNIT_DEFINES_SVH
`define ASSEMBLY_TOKEN_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define ATSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("scanner check failed");

// Next-cycle implication, disabled while in reset
`define ATSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("scanner check failed");

`endif

>>> rtl/atsu_pkg.sv
// ---------------------------------------------------------------------------
// Assembly token scanner - package
// Token kinds, character codes, keyword words and default widths.
// ---------------------------------------------------------------------------
package atsu_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 24;
  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam int unsigned LINE_BITS_DEF   = 20;

  localparam int unsigned KIND_BITS  = 5;
  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [KIND_BITS-1:0] {
    TK_END      = 5'd0,
    TK_NUMBER   = 5'd1,
    TK_IDENT    = 5'd2,
    TK_COMMA    = 5'd3,
    TK_DOT      = 5'd4,
    TK_COLON    = 5'd5,
    TK_QUESTION = 5'd6,
    TK_ERROR    = 5'd7,
    TK_CPY      = 5'd8,
    TK_REG0     = 5'd18
  } token_kind_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;

  localparam int unsigned NUM_MNEMONICS = 10;

  // Mnemonics in kind order, first character in the top byte
  localparam logic [23:0] MNEMONIC_WORDS [NUM_MNEMONICS] = '{
    24'h637079, 24'h616464, 24'h737562, 24'h6D756C, 24'h646976,
    24'h636D70, 24'h6A6D70, 24'h726574, 24'h696E63, 24'h646563
  };
  localparam logic [23:0] REG_WORD = 24'h726567;

  function automatic logic numeric_char(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic ident_lead_char(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
  endfunction

  // Keyword lookup on the first bytes of an identifier run
  function automatic logic [KIND_BITS-1:0] ident_kind(input logic [31:0] head,
                                                      input logic        len3,
                                                      input logic        len4);
    logic [KIND_BITS-1:0] kind;
    kind = TK_IDENT;
    if (len3 && head[31:24] == 8'h00) begin
      for (int i = 0; i < NUM_MNEMONICS; i++) begin
        if (head[23:0] == MNEMONIC_WORDS[i]) begin
          kind = TK_CPY + KIND_BITS'(i);
        end
      end
    end else if (len4 && head[31:8] == REG_WORD &&
                 head[7:0] >= CH_ZERO && head[7:0] <= CH_SEVEN) begin
      kind = TK_REG0 + KIND_BITS'(head[7:0] - CH_ZERO);
    end
    return kind;
  endfunction

endpackage

>>> rtl/assembly_token_scanner_unit.sv
// ---------------------------------------------------------------------------
// Assembly token scanner
// Byte-stream lexer for assembly text, one token per output beat.
// ---------------------------------------------------------------------------
// One source byte is taken per cycle and scanned against the registered mode
// (idle, number, identifier, comment) in a single pass; the tokens it causes
// (none, one or two) go into a four-entry output queue, so a byte is taken in
// every cycle while the queue has room for two tokens. A run token leaves on
// the byte after its last character; keywords are recognised from the first
// four bytes held for each identifier. Output sustains one token per cycle while
// m_axis_tready_i is high, so inputs that produce two tokens throttle the input
// side through tready. The tokens of an input beat are registered into that queue.
`include "assembly_token_scanner_unit_defines.svh"

module assembly_token_scanner_unit
  import atsu_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int unsigned LINE_BITS   = LINE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // char_code
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // token_kind, token_start, token_length, token_line, zero pad
  output logic [((KIND_BITS+OFFSET_BITS+LENGTH_BITS+LINE_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                          m_axis_tlast_o  // last_of_run
);

  localparam int unsigned TOKEN_BITS  = KIND_BITS + OFFSET_BITS + LENGTH_BITS + LINE_BITS;
  localparam int unsigned TDATA_BITS  = ((TOKEN_BITS + 7) / 8) * 8;
  localparam int unsigned PTR_BITS    = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_BITS    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT,
    MODE_COMMENT
  } mode_e;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] length;
    logic [LINE_BITS-1:0]   line;
    logic                   last;
  } token_t;

  mode_e                  mode_q, mode_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic [OFFSET_BITS-1:0] origin_q, origin_d;
  logic [LENGTH_BITS-1:0] runlen_q, runlen_d;
  logic [31:0]            head_q, head_d;
  logic [LINE_BITS-1:0]   line_q, line_d;

  token_t                 fifo_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0]    cnt_q, cnt_d;

  logic       in_fire, out_fire;
  logic [7:0] ch;
  logic       run_tok_v, sym_tok_v;
  token_t     run_tok, sym_tok;
  token_t     push_a, push_b;
  logic [1:0] push_n;
  logic       line_inc;

  assign ch       = s_axis_tdata_i;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  // Scan one byte against the current mode
  always_comb begin
    mode_e phase2_mode;
    logic  more;
    mode_d    = mode_q;
    origin_d  = origin_q;
    runlen_d  = runlen_q;
    head_d    = head_q;
    line_inc  = 1'b0;
    run_tok_v = 1'b0;
    sym_tok_v = 1'b0;
    more      = 1'b0;

    run_tok        = '0;
    run_tok.kind   = (mode_q == MODE_NUM) ? KIND_BITS'(TK_NUMBER)
                   : ident_kind(head_q, runlen_q == LENGTH_BITS'(3),
                                runlen_q == LENGTH_BITS'(4));
    run_tok.start  = origin_q;
    run_tok.length = runlen_q;
    run_tok.line   = line_q;

    sym_tok        = '0;
    sym_tok.kind   = TK_ERROR;
    sym_tok.start  = offset_q;
    sym_tok.length = LENGTH_BITS'(1);
    sym_tok.line   = line_q;

    phase2_mode = mode_q;
    if (mode_q == MODE_NUM || mode_q == MODE_IDENT) begin
      more = numeric_char(ch) || (mode_q == MODE_IDENT && ident_lead_char(ch));
      if (more) begin
        if (mode_q == MODE_IDENT && runlen_q < LENGTH_BITS'(4)) begin
          head_d = {head_q[23:0], ch};
        end
        if (runlen_q != '1) begin
          runlen_d = runlen_q + LENGTH_BITS'(1);
        end
      end else begin
        run_tok_v   = 1'b1;
        phase2_mode = MODE_IDLE;
        mode_d      = MODE_IDLE;
      end
    end

    if (phase2_mode == MODE_COMMENT) begin
      if (ch == CH_NL) begin
        line_inc = 1'b1;
        mode_d   = MODE_IDLE;
      end else if (ch == CH_NUL) begin
        mode_d         = MODE_IDLE;
        sym_tok_v      = 1'b1;
        sym_tok.kind   = TK_END;
        sym_tok.length = '0;
      end
    end else if (phase2_mode == MODE_IDLE) begin
      if (ch == CH_NUL) begin
        sym_tok_v      = 1'b1;
        sym_tok.kind   = TK_END;
        sym_tok.length = '0;
      end else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR) begin
        // skip blanks
      end else if (ch == CH_NL) begin
        line_inc = 1'b1;
      end else if (ch == CH_SEMI) begin
        mode_d = MODE_COMMENT;
      end else if (numeric_char(ch) || ident_lead_char(ch)) begin
        mode_d   = numeric_char(ch) ? MODE_NUM : MODE_IDENT;
        origin_d = offset_q;
        runlen_d = LENGTH_BITS'(1);
        head_d   = {24'h0, ch};
      end else begin
        sym_tok_v = 1'b1;
        case (ch)
          CH_COMMA: sym_tok.kind = TK_COMMA;
          CH_DOT:   sym_tok.kind = TK_DOT;
          CH_COLON: sym_tok.kind = TK_COLON;
          CH_QUERY: sym_tok.kind = TK_QUESTION;
          default:  sym_tok.kind = TK_ERROR;
        endcase
      end
    end

    line_d   = (line_inc && line_q != '1) ? line_q + LINE_BITS'(1) : line_q;
    offset_d = offset_q + OFFSET_BITS'(1);
  end

  // Order the tokens of this byte and mark the final one
  always_comb begin
    push_a      = run_tok_v ? run_tok : sym_tok;
    push_b      = sym_tok;
    push_a.last = !(run_tok_v && sym_tok_v);
    push_b.last = 1'b1;
    push_n      = in_fire ? {1'b0, run_tok_v} + {1'b0, sym_tok_v} : 2'd0;
    wr_ptr_d    = wr_ptr_q + PTR_BITS'(push_n);
    rd_ptr_d    = out_fire ? rd_ptr_q + PTR_BITS'(1) : rd_ptr_q;
    cnt_d       = cnt_q + CNT_BITS'(push_n) - CNT_BITS'(out_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      offset_q <= '0;
      origin_q <= '0;
      runlen_q <= '0;
      head_q   <= '0;
      line_q   <= LINE_BITS'(1);
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_fire) begin
        mode_q   <= mode_d;
        offset_q <= offset_d;
        origin_q <= origin_d;
        runlen_q <= runlen_d;
        head_q   <= head_d;
        line_q   <= line_d;
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= push_a;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + PTR_BITS'(1)] <= push_b;
    end
  end

  // Take a byte only while two queue slots are free
  assign s_axis_tready_o = (cnt_q <= CNT_BITS'(FIFO_DEPTH - 2));
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = TDATA_BITS'({fifo_q[rd_ptr_q].line, fifo_q[rd_ptr_q].length,
                                        fifo_q[rd_ptr_q].start, fifo_q[rd_ptr_q].kind});
  assign m_axis_tlast_o  = fifo_q[rd_ptr_q].last;

  `ATSU_ASSERT_NOW(a_queue_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_BITS'(FIFO_DEPTH))
  `ATSU_ASSERT_NEXT(a_line_monotonic, clk_i, rst_ni, 1'b1, line_q >= $past(line_q))
  `ATSU_ASSERT_NEXT(a_end_queued, clk_i, rst_ni, in_fire && ch == CH_NUL, cnt_q != '0)

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Assembly token scanner - testbench
// Streams source text into the scanner and checks every token beat against a
// local model of the lexer: a short directed table of special cases, then
// random mixes of keywords, registers, runs, comments, blanks and noise under
// three back-pressure profiles.
// ----------------------------------------------------------------------------
module tb_top;
  import atsu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OFS_W   = OFFSET_BITS_DEF;
  localparam int unsigned SPAN_W  = LENGTH_BITS_DEF;
  localparam int unsigned LINE_W  = LINE_BITS_DEF;
  localparam int unsigned TDATA_W = ((KIND_BITS + OFS_W + SPAN_W + LINE_W + 7) / 8) * 8;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [OFS_W-1:0]     start;
    logic [SPAN_W-1:0]    span;
    logic [LINE_W-1:0]    line;
    logic                 last;
  } token_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       pinned;  // expected token typed in below
    token_t     tok;
  } stim_row_t;

  typedef enum logic [1:0] {
    SCAN_IDLE, SCAN_NUMBER, SCAN_IDENT, SCAN_COMMENT
  } scan_mode_e;

  localparam int unsigned NUM_OPCODES = 10;
  localparam logic [23:0] OPCODE_WORDS [NUM_OPCODES] = '{
    "cpy", "add", "sub", "mul", "div", "cmp", "jmp", "ret", "inc", "dec"
  };
  localparam logic [7:0] SEPARATORS [4] = '{CH_SPACE, CH_COMMA, CH_NL, CH_COLON};

  localparam int unsigned NUM_ROWS = 29;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{8'h40,    1'b1, '{TK_ERROR,    24'd0,  16'd1, 20'd1, 1'b1}},
    '{CH_COMMA, 1'b1, '{TK_COMMA,    24'd1,  16'd1, 20'd1, 1'b1}},
    '{CH_DOT,   1'b1, '{TK_DOT,      24'd2,  16'd1, 20'd1, 1'b1}},
    '{CH_COLON, 1'b1, '{TK_COLON,    24'd3,  16'd1, 20'd1, 1'b1}},
    '{CH_QUERY, 1'b1, '{TK_QUESTION, 24'd4,  16'd1, 20'd1, 1'b1}},
    '{8'hFF,    1'b1, '{TK_ERROR,    24'd5,  16'd1, 20'd1, 1'b1}},
    '{CH_SPACE, 1'b0, '0},
    '{CH_TAB,   1'b0, '0},
    '{CH_CR,    1'b0, '0},
    '{CH_NL,    1'b0, '0},
    '{CH_SEMI,  1'b0, '0},
    '{"x",      1'b0, '0},
    '{CH_NL,    1'b0, '0},
    '{"c",      1'b0, '0},
    '{"p",      1'b0, '0},
    '{"y",      1'b0, '0},
    '{CH_NL,    1'b0, '0},  // keyword closed by a newline keeps the old line
    '{"r",      1'b0, '0},
    '{"e",      1'b0, '0},
    '{"g",      1'b0, '0},
    '{"7",      1'b0, '0},
    '{CH_COMMA, 1'b0, '0},  // register token, then the comma
    '{"9",      1'b0, '0},
    '{CH_NUL,   1'b0, '0},  // number, then end
    '{CH_SEMI,  1'b0, '0},
    '{CH_NUL,   1'b1, '{TK_END,      24'd25, 16'd0, 20'd4, 1'b1}},
    '{"_",      1'b0, '0},
    '{"0",      1'b0, '0},
    '{CH_QUERY, 1'b0, '0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               s_tvalid;
  logic [7:0]         s_tdata;
  logic               s_axis_tready_o;
  logic               m_axis_tvalid_o;
  logic               m_tready;
  logic [TDATA_W-1:0] m_axis_tdata_o;
  logic               m_axis_tlast_o;

  // scanner model state
  scan_mode_e        scan_mode;
  logic [OFS_W-1:0]  byte_ofs;
  logic [OFS_W-1:0]  run_origin;
  logic [SPAN_W-1:0] run_len;
  logic [31:0]       head_word;
  logic [LINE_W-1:0] line_no;
  int                produced;

  token_t expected_tokens [$];
  int     chars_sent;
  int     fail_count;
  int     src_idle_pct;
  int     sink_stall_pct;

  assembly_token_scanner_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic logic is_numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [KIND_BITS-1:0] word_kind();
    if (run_len == SPAN_W'(3)) begin
      for (int i = 0; i < NUM_OPCODES; i++) begin
        if (head_word == {8'h00, OPCODE_WORDS[i]}) return TK_CPY + KIND_BITS'(i);
      end
    end else if (run_len == SPAN_W'(4) && head_word[31:8] == "reg" &&
                 head_word[7:0] >= "0" && head_word[7:0] <= "7") begin
      return TK_REG0 + KIND_BITS'(head_word[7:0] - 8'h30);
    end
    return TK_IDENT;
  endfunction

  function automatic void add_token(input logic [KIND_BITS-1:0] kind,
                                    input logic [OFS_W-1:0] start,
                                    input logic [SPAN_W-1:0] span);
    expected_tokens.push_back('{kind, start, span, line_no, 1'b0});
    produced++;
  endfunction

  // Advance the model by one accepted byte and queue the tokens it causes
  function automatic void lex_byte(input logic [7:0] c);
    logic cont;
    produced = 0;
    if (scan_mode == SCAN_NUMBER || scan_mode == SCAN_IDENT) begin
      cont = is_numeral(c) || (scan_mode == SCAN_IDENT && is_letter(c));
      if (cont) begin
        if (scan_mode == SCAN_IDENT && run_len < SPAN_W'(4)) head_word = {head_word[23:0], c};
        if (run_len != '1) run_len = run_len + 1'b1;
      end else begin
        add_token(scan_mode == SCAN_NUMBER ? KIND_BITS'(TK_NUMBER) : word_kind(),
                  run_origin, run_len);
        scan_mode = SCAN_IDLE;
      end
    end
    if (scan_mode == SCAN_COMMENT) begin
      if (c == CH_NL) begin
        if (line_no != '1) line_no = line_no + 1'b1;
        scan_mode = SCAN_IDLE;
      end else if (c == CH_NUL) begin
        scan_mode = SCAN_IDLE;
        add_token(TK_END, byte_ofs, '0);
      end
    end else if (scan_mode == SCAN_IDLE) begin
      case (c)
        CH_NUL:                   add_token(TK_END, byte_ofs, '0);
        CH_SPACE, CH_TAB, CH_CR: begin
        end
        CH_NL: begin
          if (line_no != '1) line_no = line_no + 1'b1;
        end
        CH_SEMI:                  scan_mode = SCAN_COMMENT;
        CH_COMMA:                 add_token(TK_COMMA, byte_ofs, SPAN_W'(1));
        CH_DOT:                   add_token(TK_DOT, byte_ofs, SPAN_W'(1));
        CH_COLON:                 add_token(TK_COLON, byte_ofs, SPAN_W'(1));
        CH_QUERY:                 add_token(TK_QUESTION, byte_ofs, SPAN_W'(1));
        default: begin
          if (is_numeral(c) || is_letter(c)) begin
            scan_mode  = is_numeral(c) ? SCAN_NUMBER : SCAN_IDENT;
            run_origin = byte_ofs;
            run_len    = SPAN_W'(1);
            head_word  = {24'h0, c};
          end else begin
            add_token(TK_ERROR, byte_ofs, SPAN_W'(1));
          end
        end
      endcase
    end
    if (produced > 0) expected_tokens[expected_tokens.size()-1].last = 1'b1;
    byte_ofs = byte_ofs + 1'b1;
  endfunction

  task automatic send_char(input logic [7:0] c);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready_o);
    lex_byte(c);
    chars_sent++;
  endtask

  function automatic logic [7:0] rand_letter();
    int pick;
    pick = $urandom_range(0, 52);
    if (pick < 26) return 8'h61 + 8'(pick);
    if (pick < 52) return 8'h41 + 8'(pick - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_word_char();
    if ($urandom_range(0, 9) < 7) return rand_letter();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  // Send one lexeme; runs are usually closed by a separator
  task automatic emit_fragment();
    int          pick;
    int          n;
    logic [23:0] w;
    logic        is_run;
    logic [7:0]  b;
    pick   = $urandom_range(0, 99);
    is_run = 1'b0;
    if (pick < 25) begin
      w = OPCODE_WORDS[$urandom_range(0, NUM_OPCODES - 1)];
      send_char(w[23:16]);
      send_char(w[15:8]);
      send_char(w[7:0]);
      is_run = 1'b1;
    end else if (pick < 35) begin
      send_char("r");
      send_char("e");
      send_char("g");
      if ($urandom_range(0, 5) != 0) send_char(8'h30 + 8'($urandom_range(0, 9)));
      is_run = 1'b1;
    end else if (pick < 50) begin
      send_char(rand_letter());
      n = $urandom_range(0, 5);
      repeat (n) send_char(rand_word_char());
      is_run = 1'b1;
    end else if (pick < 62) begin
      n = $urandom_range(1, 5);
      repeat (n) send_char(8'h30 + 8'($urandom_range(0, 9)));
      is_run = 1'b1;
    end else if (pick < 70) begin
      case ($urandom_range(0, 3))
        0:       send_char(CH_COMMA);
        1:       send_char(CH_DOT);
        2:       send_char(CH_COLON);
        default: send_char(CH_QUERY);
      endcase
    end else if (pick < 80) begin
      case ($urandom_range(0, 3))
        0:       send_char(CH_SPACE);
        1:       send_char(CH_TAB);
        2:       send_char(CH_CR);
        default: send_char(CH_NL);
      endcase
    end else if (pick < 87) begin
      send_char(CH_SEMI);
      n = $urandom_range(0, 6);
      repeat (n) begin
        b = 8'($urandom_range(1, 255));
        send_char(b == CH_NL ? 8'h0B : b);
      end
      send_char($urandom_range(0, 7) == 0 ? CH_NUL : CH_NL);
    end else if (pick < 90) begin
      send_char(CH_NUL);
    end else begin
      send_char(8'($urandom_range(0, 255)));
    end
    if (is_run && $urandom_range(0, 9) < 7) send_char(SEPARATORS[$urandom_range(0, 3)]);
  endtask

  task automatic run_random(input int count);
    int target;
    target = chars_sent + count;
    while (chars_sent < target) emit_fragment();
  endtask

  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    token_t want;
    token_t got;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got.kind  = m_axis_tdata_o[KIND_BITS-1:0];
      got.start = m_axis_tdata_o[KIND_BITS +: OFS_W];
      got.span  = m_axis_tdata_o[KIND_BITS+OFS_W +: SPAN_W];
      got.line  = m_axis_tdata_o[KIND_BITS+OFS_W+SPAN_W +: LINE_W];
      got.last  = m_axis_tlast_o;
      if (expected_tokens.size() == 0) begin
        $error("unexpected token beat: kind %0d start %0d", got.kind, got.start);
        fail_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (got.kind != want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, got.kind);
          fail_count++;
        end
        if (got.start != want.start) begin
          $error("token_start: expected %0d, got %0d", want.start, got.start);
          fail_count++;
        end
        if (got.span != want.span) begin
          $error("token_length: expected %0d, got %0d", want.span, got.span);
          fail_count++;
        end
        if (got.line != want.line) begin
          $error("token_line: expected %0d, got %0d", want.line, got.line);
          fail_count++;
        end
        if (got.last != want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, got.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    scan_mode      = SCAN_IDLE;
    byte_ofs       = '0;
    run_origin     = '0;
    run_len        = '0;
    head_word      = '0;
    line_no        = LINE_W'(1);
    produced       = 0;
    chars_sent     = 0;
    fail_count     = 0;
    src_idle_pct   = 10;
    sink_stall_pct = 59;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_char(DIRECTED_ROWS[r].ch);
      if (DIRECTED_ROWS[r].pinned) begin
        // replace the modelled token with the one typed in the table
        repeat (produced) void'(expected_tokens.pop_back());
        expected_tokens.push_back(DIRECTED_ROWS[r].tok);
      end
    end
    run_random(240);

    src_idle_pct   = 59;
    sink_stall_pct = 10;
    run_random(250);

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    run_random(250);

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> assembly_token_scanner_unit.f
+incdir+rtl
rtl/atsu_pkg.sv
rtl/assembly_token_scanner_unit.sv
verif/tb_top.sv
